// ----- src/arpc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and command codes for the ARP cache with pending list.
// ----------------------------------------------------------------------------
package arpc_pkg;

    typedef enum logic [2:0] {
        CMD_LOOKUP  = 3'd0,
        CMD_UPDATE  = 3'd1,
        CMD_DELETE  = 3'd2,
        CMD_CLEAR   = 3'd3,
        CMD_RX      = 3'd4,
        CMD_MARK    = 3'd5,
        CMD_QUERY   = 3'd6,
        CMD_CANCEL  = 3'd7
    } arpc_cmd_t;

    localparam logic [15:0] OP_REQUEST = 16'd1;
    localparam logic [15:0] OP_REPLY   = 16'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_CFULL    = 2'd1;
    localparam logic [1:0] ST_PFULL    = 2'd2;
    localparam logic [1:0] ST_BADOP    = 2'd3;

    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_OUT  = 1'b1
    } arpc_state_t;

    // Controller -> datapath
    typedef struct packed {
        logic exec;     // execute the command on the input beat
        logic load;     // load the result register
    } arpc_ctl_t;

    // Result beat: found, mac_out, pending, send_reply, reply_mac, reply_ip,
    // update_notice, notice_ip, status (lowest first in tdata)
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] notice_ip;
        logic        update_notice;
        logic [31:0] reply_ip;
        logic [47:0] reply_mac;
        logic        send_reply;
        logic        pending;
        logic [47:0] mac_out;
        logic        found;
    } arpc_res_t;

endpackage

// ----- src/arp_cache_with_pending_list.sv -----
`timescale 1ns / 1ps
// The result beat is registered and is valid in the cycle after the command beat is accepted.
// Throughput: one command per cycle while the result side keeps tready high.
// The whole table compare and update is combinational and completes in the execute cycle.
// Reset (rst_n low, async) clears all valid bits, local_ip and the handshake.
// ----------------------------------------------------------------------------
// arp_cache_with_pending_list
// ARP cache with a pending request list, stream in and out.
// ----------------------------------------------------------------------------
module arp_cache_with_pending_list
    import arpc_pkg::*;
#(
    parameter int CACHE_ENTRIES   = 16,
    parameter int PENDING_ENTRIES = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // cmd[2:0], ip_addr[34:3], mac_addr[82:35], target_ip[114:83], opcode[130:115]
    input  logic [135:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // found, mac_out, pending, send_reply, reply_mac, reply_ip,
    // update_notice, notice_ip, status (lowest first)
    output logic [167:0] m_tdata,
    input  logic         cfg_we,
    input  logic [31:0]  cfg_data
);

    arpc_ctl_t ctl;
    arpc_res_t res;

    arpc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .ctl       (ctl)
    );

    arpc_dp #(
        .CACHE_ENTRIES   (CACHE_ENTRIES),
        .PENDING_ENTRIES (PENDING_ENTRIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .cmd       (s_tdata[2:0]),
        .ip_addr   (s_tdata[34:3]),
        .mac_addr  (s_tdata[82:35]),
        .target_ip (s_tdata[114:83]),
        .opcode    (s_tdata[130:115]),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .res       (res)
    );

    assign m_tdata = {2'b00, res};

endmodule

// ----- src/arpc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_ctrl
// Handshake controller: takes a command beat, runs it, holds the result.
// ----------------------------------------------------------------------------
module arpc_ctrl
    import arpc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output arpc_ctl_t ctl
);

    arpc_state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and commands; a new beat may enter as the result leaves
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.exec   = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                in_ready  = out_ready;
                if (out_ready && !in_valid)
                    state_next = S_IDLE;
                if (out_ready && in_valid)
                    ctl.exec = 1'b1;
            end
            default: state_next = S_IDLE;
        endcase
        ctl.load = ctl.exec;
    end

endmodule

// ----- src/arpc_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_dp
// Datapath: cache and pending tables, parallel match, result register.
// ----------------------------------------------------------------------------
module arpc_dp
    import arpc_pkg::*;
#(
    parameter int CACHE_ENTRIES   = 16,
    parameter int PENDING_ENTRIES = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  arpc_ctl_t   ctl,
    input  logic [2:0]  cmd,
    input  logic [31:0] ip_addr,
    input  logic [47:0] mac_addr,
    input  logic [31:0] target_ip,
    input  logic [15:0] opcode,
    input  logic        cfg_we,
    input  logic [31:0] cfg_data,
    output arpc_res_t   res
);

    localparam int CW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int PW = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;

    logic [31:0]              local_ip_reg;
    logic [CACHE_ENTRIES-1:0] cvalid_reg, cvalid_next;
    logic [31:0]              cip_reg  [CACHE_ENTRIES];
    logic [47:0]              cmac_reg [CACHE_ENTRIES];
    logic [PENDING_ENTRIES-1:0] pvalid_reg, pvalid_next;
    logic [31:0]              pip_reg  [PENDING_ENTRIES];
    arpc_res_t                res_reg, res_next;

    logic [CACHE_ENTRIES-1:0]   c_hit;
    logic [PENDING_ENTRIES-1:0] p_hit;
    logic          c_any, c_free_any, p_any, p_free_any;
    logic [CW-1:0] c_hit_idx, c_free_idx, c_put_idx;
    logic [PW-1:0] p_hit_idx, p_free_idx;
    logic          c_wr, p_wr, put_ok, do_put;
    arpc_cmd_t     cmd_e;

    assign cmd_e = arpc_cmd_t'(cmd);

    // Local IP register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            local_ip_reg <= '0;
        else if (cfg_we)
            local_ip_reg <= cfg_data;
    end

    // Parallel compare and lowest-index priority encoders
    always_comb
    begin
        c_any = 1'b0; c_free_any = 1'b0; c_hit_idx = '0; c_free_idx = '0;
        for (int i = CACHE_ENTRIES - 1; i >= 0; i--)
        begin
            c_hit[i] = cvalid_reg[i] && (cip_reg[i] == ip_addr);
            if (c_hit[i])
            begin
                c_any = 1'b1; c_hit_idx = CW'(i);
            end
            if (!cvalid_reg[i])
            begin
                c_free_any = 1'b1; c_free_idx = CW'(i);
            end
        end
        p_any = 1'b0; p_free_any = 1'b0; p_hit_idx = '0; p_free_idx = '0;
        for (int j = PENDING_ENTRIES - 1; j >= 0; j--)
        begin
            p_hit[j] = pvalid_reg[j] && (pip_reg[j] == ip_addr);
            if (p_hit[j])
            begin
                p_any = 1'b1; p_hit_idx = PW'(j);
            end
            if (!pvalid_reg[j])
            begin
                p_free_any = 1'b1; p_free_idx = PW'(j);
            end
        end
    end

    // Command decode
    always_comb
    begin
        cvalid_next = cvalid_reg;
        pvalid_next = pvalid_reg;
        res_next    = '0;
        c_put_idx   = c_any ? c_hit_idx : c_free_idx;
        put_ok      = c_any || c_free_any;
        do_put      = 1'b0;
        c_wr        = 1'b0;
        p_wr        = 1'b0;
        unique case (cmd_e)
            CMD_LOOKUP:
            begin
                res_next.found   = c_any;
                res_next.mac_out = c_any ? cmac_reg[c_hit_idx] : '0;
            end
            CMD_UPDATE: do_put = 1'b1;
            CMD_DELETE:
                if (c_any)
                    cvalid_next[c_hit_idx] = 1'b0;
            CMD_CLEAR: cvalid_next = '0;
            CMD_RX:
            begin
                if (opcode == OP_REQUEST || opcode == OP_REPLY)
                begin
                    do_put = 1'b1;
                    if (opcode == OP_REQUEST)
                    begin
                        if (target_ip == local_ip_reg)
                        begin
                            res_next.send_reply = 1'b1;
                            res_next.reply_mac  = mac_addr;
                            res_next.reply_ip   = ip_addr;
                        end
                    end
                    else if (p_any)
                        pvalid_next[p_hit_idx] = 1'b0;
                end
                else
                    res_next.status = ST_BADOP;
            end
            CMD_MARK:
            begin
                if (p_free_any)
                begin
                    p_wr = 1'b1;
                    pvalid_next[p_free_idx] = 1'b1;
                end
                else
                    res_next.status = ST_PFULL;
            end
            CMD_QUERY: res_next.pending = p_any;
            CMD_CANCEL:
                if (p_any)
                    pvalid_next[p_hit_idx] = 1'b0;
            default: ;
        endcase
        if (do_put)
        begin
            if (put_ok)
            begin
                c_wr = 1'b1;
                cvalid_next[c_put_idx] = 1'b1;
                res_next.update_notice = 1'b1;
                res_next.notice_ip     = ip_addr;
            end
            else
                res_next.status = ST_CFULL;
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cvalid_reg <= '0;
            pvalid_reg <= '0;
        end
        else if (ctl.exec)
        begin
            cvalid_reg <= cvalid_next;
            pvalid_reg <= pvalid_next;
        end
    end

    // Table contents and result register
    always_ff @(posedge clk)
    begin
        if (ctl.exec && c_wr)
        begin
            cip_reg[c_put_idx]  <= ip_addr;
            cmac_reg[c_put_idx] <= mac_addr;
        end
        if (ctl.exec && p_wr)
            pip_reg[p_free_idx] <= ip_addr;
        if (ctl.load)
            res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream testbench for the ARP cache with pending list: directed and random
// commands, a shadow table predicts every result beat, checked in order.
// ----------------------------------------------------------------------------
module tb_top;
    import arpc_pkg::*;

    localparam int NCACHE = 16;
    localparam int NPEND  = 8;

    // Shadow of the cache and pending list; predicts one result per command
    class arp_scoreboard;
        bit          c_vld[NCACHE];
        bit [31:0]   c_ip[NCACHE];
        bit [47:0]   c_mac[NCACHE];
        bit          p_vld[NPEND];
        bit [31:0]   p_ip[NPEND];
        bit [31:0]   my_ip;
        arpc_res_t   expected_q[$];
        int          errors;

        function int find_entry(bit [31:0] ip);
            for (int i = 0; i < NCACHE; i++)
                if (c_vld[i] && c_ip[i] == ip) return i;
            return -1;
        endfunction

        function int find_pend(bit [31:0] ip);
            for (int i = 0; i < NPEND; i++)
                if (p_vld[i] && p_ip[i] == ip) return i;
            return -1;
        endfunction

        function bit learn(bit [31:0] ip, bit [47:0] mac);
            int k;
            k = find_entry(ip);
            if (k < 0)
                for (int i = 0; i < NCACHE; i++)
                    if (!c_vld[i])
                    begin
                        k = i;
                        break;
                    end
            if (k < 0) return 0;
            c_vld[k] = 1;
            c_ip[k]  = ip;
            c_mac[k] = mac;
            return 1;
        endfunction

        function void note_input(bit [135:0] d);
            arpc_res_t  r;
            arpc_cmd_t  cmd;
            bit [31:0]  ip, tgt;
            bit [47:0]  mac;
            bit [15:0]  op;
            int         k;
            cmd = arpc_cmd_t'(d[2:0]);
            ip  = d[34:3];
            mac = d[82:35];
            tgt = d[114:83];
            op  = d[130:115];
            r   = '0;
            case (cmd)
                CMD_LOOKUP:
                begin
                    k = find_entry(ip);
                    if (k >= 0)
                    begin
                        r.found   = 1;
                        r.mac_out = c_mac[k];
                    end
                end
                CMD_UPDATE:
                    if (learn(ip, mac))
                    begin
                        r.update_notice = 1;
                        r.notice_ip     = ip;
                    end
                    else r.status = ST_CFULL;
                CMD_DELETE:
                begin
                    k = find_entry(ip);
                    if (k >= 0) c_vld[k] = 0;
                end
                CMD_CLEAR:
                    foreach (c_vld[i]) c_vld[i] = 0;
                CMD_RX:
                    if (op == OP_REQUEST || op == OP_REPLY)
                    begin
                        if (learn(ip, mac))
                        begin
                            r.update_notice = 1;
                            r.notice_ip     = ip;
                        end
                        else r.status = ST_CFULL;
                        if (op == OP_REQUEST)
                        begin
                            if (tgt == my_ip)
                            begin
                                r.send_reply = 1;
                                r.reply_mac  = mac;
                                r.reply_ip   = ip;
                            end
                        end
                        else
                        begin
                            k = find_pend(ip);
                            if (k >= 0) p_vld[k] = 0;
                        end
                    end
                    else r.status = ST_BADOP;
                CMD_MARK:
                begin
                    k = -1;
                    for (int i = 0; i < NPEND; i++)
                        if (!p_vld[i])
                        begin
                            k = i;
                            break;
                        end
                    if (k >= 0)
                    begin
                        p_vld[k] = 1;
                        p_ip[k]  = ip;
                    end
                    else r.status = ST_PFULL;
                end
                CMD_QUERY:
                    r.pending = (find_pend(ip) >= 0);
                default:
                begin
                    k = find_pend(ip);
                    if (k >= 0) p_vld[k] = 0;
                end
            endcase
            expected_q.insert(expected_q.size(), r);
        endfunction

        function void check_result(arpc_res_t act);
            arpc_res_t e;
            if (expected_q.size() == 0)
            begin
                $error("result beat with no expectation: %h", act);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (act.found != e.found)
                begin $error("found exp %h act %h", e.found, act.found); errors++; end
            if (act.mac_out != e.mac_out)
                begin $error("mac_out exp %h act %h", e.mac_out, act.mac_out); errors++; end
            if (act.pending != e.pending)
                begin $error("pending exp %h act %h", e.pending, act.pending); errors++; end
            if (act.send_reply != e.send_reply)
                begin $error("send_reply exp %h act %h", e.send_reply, act.send_reply);
                errors++; end
            if (act.reply_mac != e.reply_mac)
                begin $error("reply_mac exp %h act %h", e.reply_mac, act.reply_mac);
                errors++; end
            if (act.reply_ip != e.reply_ip)
                begin $error("reply_ip exp %h act %h", e.reply_ip, act.reply_ip); errors++; end
            if (act.update_notice != e.update_notice)
                begin $error("update_notice exp %h act %h", e.update_notice,
                    act.update_notice); errors++; end
            if (act.notice_ip != e.notice_ip)
                begin $error("notice_ip exp %h act %h", e.notice_ip, act.notice_ip);
                errors++; end
            if (act.status != e.status)
                begin $error("status exp %h act %h", e.status, act.status); errors++; end
        endfunction
    endclass

    logic         clk = 0;
    logic         rst_n = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [135:0] s_tdata = '0;   // cmd, ip_addr, mac_addr, target_ip, opcode
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [167:0] m_tdata;        // found, mac_out, pending, send_reply, reply_mac,
                                  // reply_ip, update_notice, notice_ip, status
    logic         cfg_we = 0;
    logic [31:0]  cfg_data = '0;

    arp_scoreboard sb = new();
    bit            rx_long;
    bit [31:0]     ip_pool[8];

    arp_cache_with_pending_list DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 1) == 0) return 0;
        return $urandom_range(1, 3);
    endfunction

    // Result side: random stalls, checks every accepted beat
    initial
    begin
        int g;
        @(posedge rst_n);
        forever
        begin
            g = rx_long ? 0 : gap_len();
            if (g > 0)
            begin
                m_tready <= 0;
                repeat (g) @(posedge clk);
            end
            m_tready <= 1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            sb.check_result(arpc_res_t'(m_tdata[165:0]));
        end
    end

    // One command beat, with a random gap before it
    task automatic send_cmd(arpc_cmd_t c, bit [31:0] ip, bit [47:0] mac,
                            bit [31:0] tgt, bit [15:0] op, bit nogap = 0);
        int g;
        g = nogap ? 0 : gap_len();
        if (g > 0)
        begin
            s_tvalid <= 0;
            repeat (g) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata  <= {5'b0, op, tgt, mac, ip, c};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_input({5'b0, op, tgt, mac, ip, c});
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_local_ip(bit [31:0] v);
        cfg_we   <= 1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 0;
        sb.my_ip = v;
    endtask

    function automatic bit [31:0] pick_ip();
        if ($urandom_range(0, 9) < 8) return ip_pool[$urandom_range(0, 7)];
        return $urandom();
    endfunction

    initial
    begin
        bit [31:0] cfgs[4];
        bit [15:0] op;
        int        r;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: extremes, cache commands and rx, table full case
        write_local_ip(32'hFFFF_FFFF);
        send_cmd(CMD_LOOKUP, 32'h0, 48'h0, 0, 0);
        send_cmd(CMD_UPDATE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 0, 0);
        send_cmd(CMD_UPDATE, 32'hFFFF_FFFF, 48'h1234_5678_9ABC, 0, 0);
        send_cmd(CMD_LOOKUP, 32'hFFFF_FFFF, 0, 0, 0);
        for (int i = 0; i < 16; i++)
            send_cmd(CMD_UPDATE, i, {16'hA5A5, 32'(i)}, 0, 0, 1);
        send_cmd(CMD_RX, 32'h55, 48'h77, 32'hFFFF_FFFF, OP_REQUEST);
        send_cmd(CMD_RX, 32'h56, 48'h78, 32'hFFFF_FFFF, 16'hFFFF);
        send_cmd(CMD_DELETE, 32'h3, 0, 0, 0);
        send_cmd(CMD_DELETE, 32'h99, 0, 0, 0);
        send_cmd(CMD_CLEAR, 0, 0, 0, 0);
        drain();

        // List full, duplicates, reply removes the lowest match
        write_local_ip(32'h0);
        for (int i = 0; i < 9; i++) send_cmd(CMD_MARK, 32'h10 + (i % 3), 0, 0, 0, 1);
        send_cmd(CMD_RX, 32'h10, 48'hFFFF_FFFF_FFFF, 32'h0, OP_REPLY);
        send_cmd(CMD_QUERY, 32'h10, 0, 0, 0);
        send_cmd(CMD_CANCEL, 32'h10, 0, 0, 0);
        send_cmd(CMD_QUERY, 32'h10, 0, 0, 0);
        send_cmd(CMD_CANCEL, 32'h12345, 0, 0, 0);
        drain();

        // Random phases over several local addresses
        cfgs = '{32'h0, 32'hFFFF_FFFF, 32'hC0A8_0001, 32'h0};
        cfgs[3] = $urandom();
        for (int ph = 0; ph < 4; ph++)
        begin
            write_local_ip(cfgs[ph]);
            foreach (ip_pool[i]) ip_pool[i] = (i == 0) ? cfgs[ph] : $urandom();
            rx_long = (ph == 2);
            for (int n = 0; n < 460; n++)
            begin
                r = $urandom_range(0, 99);
                op = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(1, 2)) : 16'($urandom());
                if (r < 12)
                    send_cmd(CMD_LOOKUP, pick_ip(), 0, 0, 0);
                else if (r < 30)
                    send_cmd(CMD_UPDATE, ($urandom_range(0, 1)) ? pick_ip() : $urandom(),
                             48'({$urandom(), $urandom()}), 0, 0);
                else if (r < 38)
                    send_cmd(CMD_DELETE, pick_ip(), 0, 0, 0);
                else if (r < 40)
                    send_cmd(CMD_CLEAR, $urandom(), 48'({$urandom(), $urandom()}), 0, 0);
                else if (r < 62)
                    send_cmd(CMD_RX, ($urandom_range(0, 1)) ? pick_ip() : $urandom(),
                             48'({$urandom(), $urandom()}), pick_ip(), op);
                else if (r < 76)
                    send_cmd(CMD_MARK, pick_ip(), 0, 0, 0);
                else if (r < 88)
                    send_cmd(CMD_QUERY, pick_ip(), 0, 0, 0);
                else
                    send_cmd(CMD_CANCEL, pick_ip(), 0, 0, 0);
            end
            rx_long = 0;
            drain();
        end

        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end
endmodule
